// ----- rtl/hll_ips_pkg.sv -----
// ----------------------------------------------------------------------------
// hll_ips_pkg
// Widths, constants and types shared by the harmonic-sum accumulator.
// ----------------------------------------------------------------------------
package hll_ips_pkg;

    localparam int HASH_BITS  = 32;
    localparam int INDEX_BITS = 16;

    localparam int FRAC_BITS  = HASH_BITS + 1 - INDEX_BITS;
    localparam int SUM_W      = HASH_BITS + 1;
    localparam int LZ_W       = $clog2(SUM_W);
    localparam int MANT_W     = 24;
    localparam int NORM_W     = SUM_W + MANT_W;
    localparam int RANK_W     = 5;
    localparam int FLOAT_W    = 32;
    localparam int EXP_W      = 8;
    // biased exponent of a sum whose top bit is set, before rounding carry
    localparam int EXP_TOP    = SUM_W - 1 + 127 - FRAC_BITS;

    typedef logic [SUM_W-1:0]      sum_t;
    typedef logic [LZ_W-1:0]       lz_t;
    typedef logic [INDEX_BITS-1:0] count_t;
    typedef logic [RANK_W-1:0]     rank_t;
    typedef logic [FLOAT_W-1:0]    float_t;

    // weight of rank zero: 1.0 in sum units
    localparam sum_t RANK0_ADD = sum_t'(1) << FRAC_BITS;

endpackage

// ----- rtl/hll_inverse_power_sum_unit.sv -----
// ----------------------------------------------------------------------------
// hll_inverse_power_sum_unit
// HyperLogLog harmonic-sum accumulator with single-precision output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, rank): one bucket rank per item. Each
//   item adds 2^-rank into a fixed-point running sum; ranks beyond the
//   fraction width add nothing but still count as a bucket.
//   Output channel (out_valid/out_ready, sum_float, last): one item per input
//   item, the updated sum as an IEEE single bit pattern, round to nearest
//   even. last marks the item that completes 2^INDEX_BITS buckets; the sum
//   and the bucket count clear after it.
//   Pipeline: three register stages (sum update, leading one detect,
//   normalize and round) lie between the accepting edge and out_valid.
//   Throughput: one item per cycle unless out_ready stalls the output, set by the sum update loop.
//   Reset: sum, bucket count and all stage valids clear; no item pending.
//   Stall: when out_ready is low the three stages fill and in_ready drops
//   only once they are all occupied; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module hll_inverse_power_sum_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  hll_ips_pkg::rank_t          rank,
    output logic                        out_valid,
    input  logic                        out_ready,
    output hll_ips_pkg::float_t         sum_float,
    output logic                        last
);

    hll_ips_pkg::sum_t   sum_reg;
    hll_ips_pkg::sum_t   sum_next;
    hll_ips_pkg::count_t cnt_reg;

    logic                a_valid_reg;
    hll_ips_pkg::sum_t   a_sum_reg;
    logic                a_last_reg;

    logic                b_valid_reg;
    hll_ips_pkg::sum_t   b_sum_reg;
    hll_ips_pkg::lz_t    b_lz_reg;
    logic                b_zero_reg;
    logic                b_last_reg;

    logic                out_valid_reg;
    hll_ips_pkg::float_t out_float_reg;
    logic                out_last_reg;

    logic                c_ready;
    logic                b_ready;
    logic                a_ready;
    logic                in_fire;
    logic                done;

    logic [hll_ips_pkg::SUM_W:0] sum_wide;
    hll_ips_pkg::sum_t   add_val;

    hll_ips_pkg::lz_t    lz_next;
    logic                zero_next;

    logic [hll_ips_pkg::NORM_W-1:0] norm;
    logic [hll_ips_pkg::MANT_W-1:0] mant;
    logic                           guard_bit;
    logic                           sticky_bit;
    logic                           round_up;
    logic [hll_ips_pkg::MANT_W:0]   mant_rnd;
    logic [hll_ips_pkg::EXP_W-1:0]  exp_val;
    hll_ips_pkg::float_t            float_next;

    assign c_ready  = !out_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;
    assign in_fire  = in_valid && a_ready;
    assign done     = (cnt_reg == '1);

    // saturating add of 2^-rank
    always_comb
    begin
        add_val  = hll_ips_pkg::RANK0_ADD >> rank;
        sum_wide = {1'b0, sum_reg} + {1'b0, add_val};
        if (sum_wide[hll_ips_pkg::SUM_W])
        begin
            sum_next = '1;
        end
        else
        begin
            sum_next = sum_wide[hll_ips_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (in_fire)
        begin
            sum_reg <= done ? '0 : sum_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // stage A: updated sum snapshot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_sum_reg  <= sum_next;
            a_last_reg <= done;
        end
    end

    // leading one detect
    always_comb
    begin
        lz_next   = '0;
        zero_next = (a_sum_reg == '0);
        for (int i = 0; i < hll_ips_pkg::SUM_W; i++)
        begin
            if (a_sum_reg[i])
            begin
                lz_next = hll_ips_pkg::LZ_W'(hll_ips_pkg::SUM_W - 1 - i);
            end
        end
    end

    // stage B
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_sum_reg  <= a_sum_reg;
            b_lz_reg   <= lz_next;
            b_zero_reg <= zero_next;
            b_last_reg <= a_last_reg;
        end
    end

    // normalize and round to nearest even
    always_comb
    begin
        norm       = {b_sum_reg, {hll_ips_pkg::MANT_W{1'b0}}} << b_lz_reg;
        mant       = norm[hll_ips_pkg::NORM_W-1 -: hll_ips_pkg::MANT_W];
        guard_bit  = norm[hll_ips_pkg::NORM_W-hll_ips_pkg::MANT_W-1];
        sticky_bit = |norm[hll_ips_pkg::NORM_W-hll_ips_pkg::MANT_W-2:0];
        round_up   = guard_bit && (sticky_bit || mant[0]);
        mant_rnd   = {1'b0, mant} + {{hll_ips_pkg::MANT_W{1'b0}}, round_up};
        exp_val    = hll_ips_pkg::EXP_W'(hll_ips_pkg::EXP_TOP - int'(b_lz_reg)
                                         + int'(mant_rnd[hll_ips_pkg::MANT_W]));
        if (b_zero_reg)
        begin
            float_next = '0;
        end
        else if (mant_rnd[hll_ips_pkg::MANT_W])
        begin
            float_next = {1'b0, exp_val, 23'b0};
        end
        else
        begin
            float_next = {1'b0, exp_val, mant_rnd[22:0]};
        end
    end

    // stage C: output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && b_valid_reg)
        begin
            out_float_reg <= float_next;
            out_last_reg  <= b_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign sum_float = out_float_reg;
    assign last      = out_last_reg;

endmodule

// ----- rtl/hll_ips_checker.sv -----
// ----------------------------------------------------------------------------
// hll_ips_checker
// Port-level checks of the harmonic-sum accumulator output.
// ----------------------------------------------------------------------------
module hll_ips_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input hll_ips_pkg::float_t sum_float,
    input logic                last
);

    // stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sum_float) && $stable(last))
        else $error("output item changed while stalled");

    // sum is never negative
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !sum_float[31])
        else $error("negative sum");

    // no inf or nan
    a_no_inf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sum_float[30:23] != 8'hFF))
        else $error("sum exponent all ones");

    // no denormals: either exact zero or normal
    a_normal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sum_float == 32'h0) || (sum_float[30:23] != 8'h00))
        else $error("denormal sum");

endmodule

bind hll_inverse_power_sum_unit hll_ips_checker u_hll_ips_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sum_float (sum_float),
    .last      (last)
);
